// ===== rtl/core/dfapm_pkg.sv =====
// ----------------------------------------------------------------------------
// dfapm_pkg
// Shared codes and widths for the table-driven DFA prefix matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dfapm_pkg;

  localparam int SYM_W       = 8;
  localparam int FUNC_W      = 2;
  localparam int MATCH_LEN_W = 16;
  localparam int OUT_FIELD_W = MATCH_LEN_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [MATCH_LEN_W-1:0] LEN_OUT_MAX = '1;
  localparam logic [SYM_W-1:0]       HIGH_BYTE   = 8'h80;

  // bit positions inside a state's mark entry
  localparam int MARK_FINAL = 0;
  localparam int MARK_LAZY  = 1;

  localparam logic MODE_PREFIX = 1'b0;
  localparam logic MODE_WHOLE  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_TRANS = 2'd0,
    FUNC_LOAD_MARKS = 2'd1,
    FUNC_MATCH      = 2'd2
  } func_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfa_prefix_matcher.sv =====
// ----------------------------------------------------------------------------
// dfa_prefix_matcher
// Table-driven DFA scanner: longest accepted prefix with lazy stop, or
// whole-string acceptance, over a byte stream loaded and fed as beats.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  cfg     | in  | cfg_wr_en            | cfg_wr_data = match_mode
//  in      | in  | in_tvalid/in_tready  | tdata, tuser = func, tlast = last_char
//  out     | out | out_tvalid/out_tready| tdata = matched, match_length
//
//  One beat per cycle unless stalled, loads and characters alike. The transition
//  memory read for a character is addressed by the state coming out of the
//  previous read, so the state loop closes through one read port each cycle.
//  A string's result is registered on out after the step and mark stages. Reset
//  is synchronous; both memories are left unset until loaded (no clearing pass).
//  in_tready drops only while a result waits on out and a second one is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_prefix_matcher #(
  parameter  int STATE_COUNT  = 64,
  parameter  int SYMBOL_COUNT = 128,
  parameter  int LENGTH_BITS  = 16,
  localparam int SB           = $clog2(STATE_COUNT),
  localparam int NXT_W        = SB + 1,
  localparam int IN_TDATA_W   = ((SB + dfapm_pkg::SYM_W + NXT_W + 2 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,  // match_mode
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // state_index, symbol, next_state, is_final, is_lazy, zero fill
  input  logic [IN_TDATA_W-1:0]            in_tdata,
  input  logic [dfapm_pkg::FUNC_W-1:0]     in_tuser,     // func
  input  logic                             in_tlast,     // last_char
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // matched, match_length, zero fill
  output logic [dfapm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dfapm_pkg::*;

  localparam int YB   = $clog2(SYMBOL_COUNT);
  localparam int AW   = SB + YB;
  localparam int TD   = 1 << AW;
  localparam int MD   = 1 << SB;
  localparam int LB   = LENGTH_BITS;
  localparam int CW   = (LB > MATCH_LEN_W) ? LB : MATCH_LEN_W;
  localparam int OPAD = OUT_TDATA_W - OUT_FIELD_W;
  localparam logic [LB-1:0] LEN_MAX = '1;

  // field decode
  logic [SB-1:0]    f_idx;
  logic [SYM_W-1:0] f_sym;
  logic [NXT_W-1:0] f_nxt;
  logic             f_fin;
  logic             f_lazy;
  logic             idx_ok;
  logic             sym_in_table;
  logic             sym_ok;
  logic             nxt_none;

  assign f_idx  = in_tdata[SB-1:0];
  assign f_sym  = in_tdata[SB +: SYM_W];
  assign f_nxt  = in_tdata[SB+SYM_W +: NXT_W];
  assign f_fin  = in_tdata[SB+SYM_W+NXT_W];
  assign f_lazy = in_tdata[SB+SYM_W+NXT_W+1];

  assign idx_ok       = {1'b0, f_idx} < (SB+1)'(STATE_COUNT);
  assign sym_in_table = {1'b0, f_sym} < (SYM_W+1)'(SYMBOL_COUNT);
  assign sym_ok       = sym_in_table && (f_sym < HIGH_BYTE);
  assign nxt_none     = f_nxt >= NXT_W'(STATE_COUNT);

  // handshake
  logic stall;
  logic advance;
  logic in_acc;
  logic acc_trans;
  logic acc_marks;
  logic acc_match;

  assign advance   = !stall;
  assign in_tready = advance;
  assign in_acc    = in_tvalid && advance;

  always_comb begin
    acc_trans = 1'b0;
    acc_marks = 1'b0;
    acc_match = 1'b0;
    unique case (in_tuser)
      FUNC_LOAD_TRANS: acc_trans = in_acc && idx_ok && sym_in_table;
      FUNC_LOAD_MARKS: acc_marks = in_acc && idx_ok;
      FUNC_MATCH:      acc_match = in_acc;
      default: ;
    endcase
  end

  // registers
  logic             mode_r;
  logic [SB:0]      trans_mem [TD];
  logic [SB:0]      trans_rd_r;
  logic [1:0]       marks_mem [MD];
  logic [1:0]       marks_rd_r;

  logic             b_valid_r;
  logic             b_last_r;
  logic             b_symok_r;
  logic [SB-1:0]    cur_r;
  logic             dead_r;
  logic [LB-1:0]    chars_r;

  logic             c_valid_r;
  logic             c_last_r;
  logic             c_live_r;
  logic             c_dead_r;
  logic [SB-1:0]    c_state_r;
  logic [LB-1:0]    c_chars_r;
  logic             accept_r;
  logic [LB-1:0]    best_r;
  logic             stop_r;

  logic             out_valid_r;
  logic             out_matched_r;
  logic [MATCH_LEN_W-1:0] out_len_r;

  // step stage: the transition read is back, move the state
  logic          stop_eff;
  logic          b_skip;
  logic          b_live;
  logic          b_kill;
  logic [SB-1:0] b_state;
  logic [LB-1:0] b_chars;
  logic          b_dead;
  logic [SB-1:0] ns_state;
  logic [AW-1:0] trans_ra;
  logic [AW-1:0] trans_wa;

  // a stop flag left by a string that ends in the mark stage is not ours
  assign stop_eff = stop_r && !(c_valid_r && c_last_r);
  assign b_skip   = dead_r || stop_eff;
  assign b_live   = b_valid_r && !b_skip && b_symok_r && !trans_rd_r[SB];
  assign b_kill   = b_valid_r && !b_skip && !(b_symok_r && !trans_rd_r[SB]);
  assign b_state  = b_live ? trans_rd_r[SB-1:0] : cur_r;
  assign b_chars  = (b_live && chars_r != LEN_MAX) ? chars_r + LB'(1) : chars_r;
  assign b_dead   = dead_r || b_kill;
  assign ns_state = (b_valid_r && b_last_r) ? '0 : b_state;

  assign trans_ra = {ns_state, f_sym[YB-1:0]};
  assign trans_wa = {f_idx, f_sym[YB-1:0]};

  // mark stage: marks of the entered state are back
  logic          c_final;
  logic          c_lazy;
  logic          c_hit;
  logic          c_stop;
  logic          rollback;
  logic          acc_upd;
  logic [LB-1:0] best_upd;
  logic          res_valid;
  logic          whole_ok;
  logic          res_matched;
  logic [LB-1:0] res_len_full;
  logic [CW-1:0] res_len_ext;
  logic [MATCH_LEN_W-1:0] res_len;

  assign c_final  = marks_rd_r[MARK_FINAL];
  assign c_lazy   = marks_rd_r[MARK_LAZY];
  assign c_hit    = c_valid_r && c_live_r && !stop_r && c_final;
  assign c_stop   = c_hit && c_lazy && (mode_r == MODE_PREFIX);
  // the character behind a lazy stop already moved the state: restore it
  assign rollback = c_stop && !c_last_r;
  assign acc_upd  = accept_r || c_hit;
  assign best_upd = c_hit ? c_chars_r : best_r;

  assign res_valid    = c_valid_r && c_last_r;
  assign whole_ok     = !c_dead_r && c_final;
  assign res_matched  = (mode_r == MODE_WHOLE) ? whole_ok : acc_upd;
  assign res_len_full = (mode_r == MODE_WHOLE) ? (whole_ok ? c_chars_r : '0) : best_upd;
  assign res_len_ext  = CW'(res_len_full);
  assign res_len      = (res_len_ext > CW'(LEN_OUT_MAX)) ? LEN_OUT_MAX
                                                         : res_len_ext[MATCH_LEN_W-1:0];

  assign stall = res_valid && out_valid_r && !out_tready;

  // transition memory: write on load, read on character accept
  always_ff @(posedge clk) begin
    if (acc_trans) begin
      trans_mem[trans_wa] <= {nxt_none, nxt_none ? {SB{1'b0}} : f_nxt[SB-1:0]};
    end
    if (acc_match) begin
      trans_rd_r <= trans_mem[trans_ra];
    end
  end

  // marks memory: read-before-write keeps a later load out of an earlier read
  always_ff @(posedge clk) begin
    if (acc_marks) begin
      marks_mem[f_idx] <= {f_lazy, f_fin};
    end
    if (advance && b_valid_r) begin
      marks_rd_r <= marks_mem[b_state];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PREFIX;
      b_valid_r   <= 1'b0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      chars_r     <= '0;
      c_valid_r   <= 1'b0;
      accept_r    <= 1'b0;
      best_r      <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (advance) begin
        b_valid_r <= acc_match;
        c_valid_r <= b_valid_r;
        if (b_valid_r && b_last_r) begin
          cur_r   <= '0;
          dead_r  <= 1'b0;
          chars_r <= '0;
        end else if (rollback) begin
          cur_r   <= c_state_r;
          dead_r  <= 1'b0;
          chars_r <= c_chars_r;
        end else begin
          cur_r   <= b_state;
          dead_r  <= b_dead;
          chars_r <= b_chars;
        end
        if (c_valid_r) begin
          if (c_last_r) begin
            accept_r <= 1'b0;
            best_r   <= '0;
            stop_r   <= 1'b0;
          end else begin
            accept_r <= acc_upd;
            best_r   <= best_upd;
            stop_r   <= stop_r || c_stop;
          end
        end
        if (res_valid) begin
          out_valid_r <= 1'b1;
        end else if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // payload, qualified by the valid bits above
  always_ff @(posedge clk) begin
    if (advance) begin
      b_last_r  <= in_tlast;
      b_symok_r <= sym_ok;
      c_last_r  <= b_last_r;
      c_live_r  <= b_live;
      c_dead_r  <= b_dead;
      c_state_r <= b_state;
      c_chars_r <= b_chars;
      if (res_valid) begin
        out_matched_r <= res_matched;
        out_len_r     <= res_len;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OPAD{1'b0}}, out_len_r, out_matched_r};

endmodule

`default_nettype wire

// ===== rtl/core/dfapm_checker.sv =====
// ----------------------------------------------------------------------------
// dfapm_checker
// Port-level checks on the DFA prefix matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfapm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dfapm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dfapm_pkg::*;

  // leave reset empty and ready
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("not idle after reset");

  // input back-pressure only while a result is blocked on the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  // a match always covers at least one character, a miss reports none
  a_len_vs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[MATCH_LEN_W:1] != '0)))
    else $error("match flag and length disagree");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind dfa_prefix_matcher dfapm_checker u_dfapm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== sim/dfa_scan_check_pkg.sv =====
// ----------------------------------------------------------------------------
// dfa_scan_check_pkg
// Beat and result types plus a scoreboard that mirrors the DFA scan: it keeps
// its own copy of the transition table, the state marks and the scan state,
// works out the verdict of each finished string and checks the result beats.
// ----------------------------------------------------------------------------
package dfa_scan_check_pkg;

  import dfapm_pkg::*;

  localparam int STATES     = 64;
  localparam int SYMBOLS    = 128;
  localparam int IDX_W      = 6;
  localparam int NEXT_W     = IDX_W + 1;
  localparam int IN_TDATA_W = ((IDX_W + SYM_W + NEXT_W + 2 + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;
  localparam logic [NEXT_W-1:0] NO_TRANS     = NEXT_W'(STATES);
  localparam int                REPORT_LIMIT = 10;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  state_idx;
    logic [SYM_W-1:0]  symbol;
    logic [NEXT_W-1:0] next_state;
    logic              is_final;
    logic              is_lazy;
    logic              last_char;
  } dfa_beat_t;

  typedef struct {
    logic                   matched;
    logic [MATCH_LEN_W-1:0] match_len;
  } verdict_t;

  class dfa_scan_model;
    logic [NEXT_W-1:0]      trans [STATES*SYMBOLS];
    bit                     trans_known [STATES*SYMBOLS];
    logic [1:0]             marks [STATES];
    logic                   mode;
    logic [IDX_W-1:0]       cur_state;
    bit                     stopped;
    bit                     dead;
    bit                     accepted;
    logic [MATCH_LEN_W-1:0] chars;
    logic [MATCH_LEN_W-1:0] best_len;
    verdict_t               verdicts [$];
    int unsigned            mismatches;

    function new();
      mode       = MODE_PREFIX;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      cur_state = '0;
      stopped   = 1'b0;
      dead      = 1'b0;
      accepted  = 1'b0;
      chars     = '0;
      best_len  = '0;
    endfunction

    function int unsigned outstanding();
      return verdicts.size();
    endfunction

    // a character is safe when it cannot look up an entry that was never loaded
    function bit char_is_safe(input logic [SYM_W-1:0] sym);
      if (dead || stopped || sym >= SYMBOLS) return 1'b1;
      return trans_known[int'(cur_state) * SYMBOLS + int'(sym)];
    endfunction

    function void advance(input logic [SYM_W-1:0] sym);
      logic [NEXT_W-1:0] tgt;
      if (dead || stopped) return;
      if (sym >= HIGH_BYTE || sym >= SYMBOLS) begin
        dead = 1'b1;
        return;
      end
      tgt = trans[int'(cur_state) * SYMBOLS + int'(sym)];
      if (tgt >= STATES) begin
        dead = 1'b1;
        return;
      end
      cur_state = tgt[IDX_W-1:0];
      if (chars != LEN_OUT_MAX) chars = chars + 1'b1;
      if (marks[cur_state][MARK_FINAL]) begin
        accepted = 1'b1;
        best_len = chars;
        if (mode == MODE_PREFIX && marks[cur_state][MARK_LAZY]) stopped = 1'b1;
      end
    endfunction

    function void note_beat(input dfa_beat_t b);
      verdict_t v;
      case (b.func)
        FUNC_LOAD_TRANS: begin
          if (b.symbol < SYMBOLS) begin
            trans[int'(b.state_idx) * SYMBOLS + int'(b.symbol)] =
                (b.next_state >= STATES) ? NO_TRANS : b.next_state;
            trans_known[int'(b.state_idx) * SYMBOLS + int'(b.symbol)] = 1'b1;
          end
        end
        FUNC_LOAD_MARKS: begin
          marks[b.state_idx][MARK_FINAL] = b.is_final;
          marks[b.state_idx][MARK_LAZY]  = b.is_lazy;
        end
        FUNC_MATCH: begin
          advance(b.symbol);
          if (b.last_char) begin
            if (mode == MODE_PREFIX) begin
              v.matched   = accepted;
              v.match_len = best_len;
            end else begin
              v.matched   = !dead && marks[cur_state][MARK_FINAL];
              v.match_len = v.matched ? chars : '0;
            end
            verdicts.push_back(v);
            restart();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] tdata);
      verdict_t got;
      verdict_t want;
      got.matched   = tdata[0];
      got.match_len = tdata[MATCH_LEN_W:1];
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result beat with none expected: matched=%0b length=%0d",
                   got.matched, got.match_len);
        return;
      end
      want = verdicts.pop_front();
      if (got.matched !== want.matched || got.match_len !== want.match_len) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: expected matched=%0b length=%0d, got matched=%0b length=%0d",
                   want.matched, want.match_len, got.matched, got.match_len);
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_dfa_prefix_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_dfa_prefix_matcher
// Loads DFAs into the matcher and feeds strings through it in both modes:
// a directed pass over dead transitions, high bytes, lazy stops and mode
// changes, then random DFAs with random strings. Both stream sides idle at
// random and the receiver holds off once for a long stretch; every result
// beat is checked in order.
// ----------------------------------------------------------------------------
module tb_dfa_prefix_matcher;

  timeunit 1ns;
  timeprecision 1ps;

  import dfapm_pkg::*;
  import dfa_scan_check_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 2000;
  localparam int IDLE_PCT       = 30;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [FUNC_W-1:0]      in_tuser    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic          calm         = 1'b0;
  int unsigned   stall_ticket = 0;
  int unsigned   stall_served = 0;
  int unsigned   stall_left   = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   beats_sent   = 0;
  dfa_scan_model scan_model   = new();

  dfa_prefix_matcher i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // state_index, symbol, next_state, is_final, is_lazy
    .in_tuser    (in_tuser),   // func
    .in_tlast    (in_tlast),   // last_char
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)   // matched, match_length
  );

  always #2 clk = ~clk;

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scan_model.check_result(out_tdata);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_ticket != stall_served) begin
      stall_served <= stall_ticket;
      stall_left   <= STALL_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("dfa_prefix_matcher test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic dfa_beat_t rand_beat();
    dfa_beat_t b;
    b.func       = FUNC_W'($urandom_range(3));
    b.state_idx  = IDX_W'($urandom);
    b.symbol     = SYM_W'($urandom);
    b.next_state = NEXT_W'($urandom);
    b.is_final   = 1'($urandom_range(1));
    b.is_lazy    = 1'($urandom_range(1));
    b.last_char  = 1'($urandom_range(1));
    return b;
  endfunction

  task automatic send_beat(input dfa_beat_t b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.func;
    in_tlast  <= b.last_char;
    in_tdata  <= IN_TDATA_W'({b.is_lazy, b.is_final, b.next_state, b.symbol, b.state_idx});
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    scan_model.note_beat(b);
    beats_sent++;
  endtask

  task automatic load_trans(input int s, input int sym, input int nxt);
    dfa_beat_t b = rand_beat();
    b.func       = FUNC_LOAD_TRANS;
    b.state_idx  = IDX_W'(s);
    b.symbol     = SYM_W'(sym);
    b.next_state = NEXT_W'(nxt);
    send_beat(b);
  endtask

  task automatic load_marks(input int s, input bit fin, input bit lzy);
    dfa_beat_t b = rand_beat();
    b.func      = FUNC_LOAD_MARKS;
    b.state_idx = IDX_W'(s);
    b.is_final  = fin;
    b.is_lazy   = lzy;
    send_beat(b);
  endtask

  task automatic feed(input int sym, input bit last);
    dfa_beat_t b = rand_beat();
    b.func      = FUNC_MATCH;
    b.symbol    = SYM_W'(sym);
    b.last_char = last;
    send_beat(b);
  endtask

  // drop valid, let every expected result arrive, then give the pipe time to empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (scan_model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    scan_model.mode  = m;
  endtask

  task automatic run_phase(input int unsigned phase);
    logic [IDX_W-1:0] states [$];
    logic [SYM_W-1:0] alpha [$];
    dfa_beat_t        b;
    int unsigned      n_states;
    int unsigned      str_len;
    int unsigned      r;
    logic [SYM_W-1:0] sym;
    drain();
    set_mode(phase[0] ? MODE_WHOLE : MODE_PREFIX);
    if (phase == 4) calm <= 1'b1;
    if (phase == 0)
      for (int s = 0; s < STATES; s++)
        load_marks(s, 1'($urandom_range(1)), $urandom_range(3) == 0);
    n_states = $urandom_range(8, 2);
    states.push_back('0);
    repeat (n_states - 1) states.push_back(IDX_W'($urandom));
    repeat ($urandom_range(6, 1)) alpha.push_back(SYM_W'($urandom_range(SYMBOLS - 1)));
    if ($urandom_range(3) == 0) alpha.push_back('0);
    if ($urandom_range(3) == 0) alpha.push_back(SYM_W'(SYMBOLS - 1));
    foreach (states[i])
      load_marks(int'(states[i]), $urandom_range(2) != 0, $urandom_range(3) == 0);
    foreach (states[i])
      foreach (alpha[j])
        load_trans(int'(states[i]), int'(alpha[j]),
                   ($urandom_range(9) == 0) ? int'($urandom_range(127, STATES))
                                            : int'(states[$urandom_range(states.size() - 1)]));
    // short strings while the receiver holds off, so results pile up
    if (phase == 2) stall_ticket <= stall_ticket + 1;
    repeat ($urandom_range(30, 15)) begin
      if (phase == 2) str_len = $urandom_range(3, 1);
      else if ($urandom_range(7) == 0) str_len = $urandom_range(40, 1);
      else str_len = $urandom_range(10, 1);
      for (int k = 0; k < str_len; k++) begin
        if ($urandom_range(99) < 5) begin
          b = rand_beat();
          if (b.func == FUNC_MATCH) b.func = FUNC_SPARE;
          send_beat(b);
        end
        r = $urandom_range(99);
        if (r < 82) sym = alpha[$urandom_range(alpha.size() - 1)];
        else if (r < 92) sym = SYM_W'($urandom);
        else sym = HIGH_BYTE | SYM_W'($urandom_range(SYMBOLS - 1));
        // steer off unloaded entries: a high byte kills the scan instead
        if (!scan_model.char_is_safe(sym)) sym = sym | HIGH_BYTE;
        feed(int'(sym), k == str_len - 1);
      end
    end
    if (phase == 4) calm <= 1'b0;
  endtask

  initial begin
    dfa_beat_t   b;
    int unsigned phase;
    int unsigned start_beats;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small DFA: 0 -0-> 1 (final), 1 -127-> 63 (final, lazy), 63 -0-> none,
    // 1 -0-> none, 0 -127-> 2, 2 -0-> 0 (lazy but not final)
    load_marks(0, 1'b0, 1'b1);
    load_marks(1, 1'b1, 1'b0);
    load_marks(2, 1'b0, 1'b0);
    load_marks(63, 1'b1, 1'b1);
    load_trans(0, 0, 1);
    load_trans(1, 127, 63);
    load_trans(63, 0, STATES);
    load_trans(1, 0, 127);
    load_trans(0, 127, 2);
    load_trans(2, 0, 0);
    load_trans(0, 200, 2);
    b = rand_beat();
    b.func = FUNC_SPARE;
    send_beat(b);

    feed(0, 1'b1);
    feed(0, 1'b0);
    feed(127, 1'b0);
    feed(0, 1'b1);
    feed(int'(HIGH_BYTE), 1'b1);
    feed(0, 1'b0);
    feed(0, 1'b0);
    feed('hFF, 1'b1);
    feed(127, 1'b0);
    feed(0, 1'b0);
    feed(0, 1'b1);
    // leave a lazily stopped scan open across the mode change
    feed(0, 1'b0);
    feed(127, 1'b0);
    drain();
    set_mode(MODE_WHOLE);
    feed(0, 1'b1);
    feed(0, 1'b0);
    feed(127, 1'b0);
    feed(0, 1'b1);
    feed(0, 1'b0);
    feed(127, 1'b1);

    phase       = 0;
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS || phase < 6) begin
      run_phase(phase);
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (scan_model.mismatches == 0 && scan_model.outstanding() == 0)
      $display("dfa_prefix_matcher test passed");
    else
      $display("dfa_prefix_matcher test failed");
    $finish;
  end

endmodule
